[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL: clocked checks with reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check, with the clock and reset names of this project
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

[hdl/lfs_pkg.sv]
// ---------------------------------------------------------------------------
// lfs_pkg
// Widths, constants and the bus type of the level-from-total datapath.
// ---------------------------------------------------------------------------
package lfs_pkg;

    // Field and datapath widths
    localparam int FIELD_W    = 31;
    localparam int SUM_W      = 33;
    localparam int X_W        = 31;   // total / 4
    localparam int PROD_W     = 63;   // X_W + 32
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = 17;
    localparam int LEVEL_W    = 13;
    localparam int ROOT_STEPS = 16;

    // Divide by 25 as multiply by floor(2^36 / 25), then one correction step
    localparam logic [31:0] DIV_RECIP = 32'hA3D7_0A3D;
    localparam int          DIV_SHIFT = 36;
    localparam int          Q_W       = PROD_W - DIV_SHIFT;
    localparam logic [31:0] DIV_BY    = 32'd25;

    // Largest level the input range can give
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 13'd8026;

    // Data handed from one root cell to the next
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_bus;

endpackage

[hdl/lfs_div100.sv]
// ---------------------------------------------------------------------------
// lfs_div100
// Four-stage front end: exact sum of the three counts, then truncating
// divide by 100 (shift by two, reciprocal multiply by 1/25, correction).
// ---------------------------------------------------------------------------
module lfs_div100 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lfs_pkg::FIELD_W-1:0]     i_word_count,
    input  logic [lfs_pkg::FIELD_W-1:0]     i_minute_count,
    input  logic [lfs_pkg::FIELD_W-1:0]     i_bonus_points,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lfs_pkg::RAD_W-1:0]       o_rad
);

    logic r_va, r_vb, r_vc, r_vd;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    logic [lfs_pkg::SUM_W-1:0]  n_sum;
    logic [lfs_pkg::X_W-1:0]    r_xa, r_xb, r_xc;
    logic [lfs_pkg::PROD_W-1:0] n_prod, r_prod;
    logic [lfs_pkg::Q_W-1:0]    n_q, r_qc;
    logic [31:0]                n_q25, r_q25;
    logic [31:0]                n_diff;
    logic [lfs_pkg::RAD_W-1:0]  n_rad, r_rad;

    // A stage moves on when the one after it is empty or moving
    assign rdy_d   = !r_vd || i_ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // Stage A: exact sum, keep total / 4
    assign n_sum = lfs_pkg::SUM_W'(i_word_count) + lfs_pkg::SUM_W'(i_minute_count)
                 + lfs_pkg::SUM_W'(i_bonus_points);

    // Stage B: multiply by the reciprocal of 25
    assign n_prod = lfs_pkg::PROD_W'(r_xa) * lfs_pkg::PROD_W'(lfs_pkg::DIV_RECIP);

    // Stage C: estimate is low by at most one; form estimate * 25 by shift-add
    assign n_q   = r_prod[lfs_pkg::PROD_W-1:lfs_pkg::DIV_SHIFT];
    assign n_q25 = 32'({n_q, 4'b0000}) + 32'({n_q, 3'b000}) + 32'(n_q);

    // Stage D: bump the estimate where the remainder still holds a 25
    assign n_diff = 32'(r_xc) - r_q25;
    assign n_rad  = lfs_pkg::RAD_W'(r_qc) + ((n_diff >= lfs_pkg::DIV_BY) ? 32'd1 : 32'd0);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
        end
    end

    // Payload, loaded only as an item moves in
    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_xa <= n_sum[lfs_pkg::SUM_W-1:2];
        end
        if (rdy_b && r_va) begin
            r_prod <= n_prod;
            r_xb   <= r_xa;
        end
        if (rdy_c && r_vb) begin
            r_qc  <= n_q;
            r_q25 <= n_q25;
            r_xc  <= r_xb;
        end
        if (rdy_d && r_vc) begin
            r_rad <= n_rad;
        end
    end

    assign o_valid = r_vd;
    assign o_rad   = r_rad;

endmodule

[hdl/lfs_root_cell.sv]
// ---------------------------------------------------------------------------
// lfs_root_cell
// One step of the restoring square root: bring down two radicand bits,
// try 4*root+1 against the remainder, keep one root bit. Registered.
// ---------------------------------------------------------------------------
module lfs_root_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lfs_pkg::t_root_bus i_bus,
    output logic               o_valid,
    input  logic               i_ready,
    output lfs_pkg::t_root_bus o_bus
);

    logic               r_valid;
    lfs_pkg::t_root_bus r_bus, n_bus;
    logic [lfs_pkg::REM_W+1:0] rem_sh;
    logic [lfs_pkg::REM_W+1:0] trial;
    logic                      take;

    assign o_ready = !r_valid || i_ready;

    // Trial subtract of the shifted remainder
    assign rem_sh = {i_bus.rem, i_bus.rad[lfs_pkg::RAD_W-1 -: 2]};
    assign trial  = (lfs_pkg::REM_W+2)'({i_bus.root, 2'b01});
    assign take   = (rem_sh >= trial);

    always_comb begin
        n_bus.rad  = {i_bus.rad[lfs_pkg::RAD_W-3:0], 2'b00};
        if (take) begin
            n_bus.rem  = lfs_pkg::REM_W'(rem_sh - trial);
            n_bus.root = {i_bus.root[lfs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_bus.rem  = rem_sh[lfs_pkg::REM_W-1:0];
            n_bus.root = {i_bus.root[lfs_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // Hold while the next cell is full and stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

[hdl/level_from_scaled_total_isqrt.sv]
// ---------------------------------------------------------------------------
// level_from_scaled_total_isqrt
// Level = floor(sqrt((word_count + minute_count + bonus_points) / 100)).
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake              tdata fields (low bit up)
// s_axis    in   i_s_tvalid/o_s_tready  word_count[30:0] minute_count[61:31]
//                                       bonus_points[92:62], zero[95:93]
// m_axis    out  o_m_tvalid/i_m_tready  level[12:0], zero[15:13]
//
// One item per cycle while the output is not stalled; four front stages (sum,
// reciprocal multiply, shift-add of the estimate, correction) then 16 root cells.
// Every stage has its own valid bit and frees itself when the next one is
// empty or moving, so bubbles close up under an output stall.
// The last root cell is the output register.
// Synchronous active-low reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module level_from_scaled_total_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // word_count[30:0], minute_count[61:31], bonus_points[92:62], zero[95:93]
    input  logic [95:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // level[12:0], zero[15:13]
    output logic [15:0] o_m_tdata
);

    localparam int N = lfs_pkg::ROOT_STEPS;

    logic                      front_valid;
    logic [lfs_pkg::RAD_W-1:0] front_rad;
    logic                      cell_valid [N+1];
    logic                      cell_ready [N+1];
    lfs_pkg::t_root_bus        cell_bus   [N+1];

    // Sum and divide by 100
    lfs_div100 u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_word_count   (i_s_tdata[30:0]),
        .i_minute_count (i_s_tdata[61:31]),
        .i_bonus_points (i_s_tdata[92:62]),
        .o_valid        (front_valid),
        .i_ready        (cell_ready[0]),
        .o_rad          (front_rad)
    );

    // Chain entry: empty remainder and root
    assign cell_valid[0]    = front_valid;
    assign cell_bus[0].rad  = front_rad;
    assign cell_bus[0].rem  = '0;
    assign cell_bus[0].root = '0;

    // One cell per root bit
    for (genvar g = 0; g < N; g++) begin : g_cell
        lfs_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .o_ready (cell_ready[g]),
            .i_bus   (cell_bus[g]),
            .o_valid (cell_valid[g+1]),
            .i_ready (cell_ready[g+1]),
            .o_bus   (cell_bus[g+1])
        );
    end

    assign cell_ready[N] = i_m_tready;
    assign o_m_tvalid    = cell_valid[N];
    assign o_m_tdata     = {3'b000, cell_bus[N].root[lfs_pkg::LEVEL_W-1:0]};

    // Checks
    `ASSERT_STD(a_level_range,
        o_m_tvalid |-> (o_m_tdata[12:0] <= lfs_pkg::LEVEL_MAX),
        "level above the reachable maximum")
    `ASSERT_STD(a_root_fits,
        o_m_tvalid |-> (cell_bus[N].root[lfs_pkg::ROOT_W-1:lfs_pkg::LEVEL_W] == 3'b000),
        "root wider than the level field")
    `ASSERT_STD(a_ready_when_empty,
        !o_m_tvalid |-> o_s_tready,
        "input blocked with the output register empty")

endmodule
